@@ hdl/lhe_pkg.sv @@
// Shared constants, command types and codes for the luma histogram engine.
package lhe_pkg;

  localparam int COUNT_BITS = 32;
  localparam int NUM_BINS   = 256;
  localparam int BIN_BITS   = $clog2(NUM_BINS);
  localparam int PIX_BITS   = 8;
  localparam int OUT_BITS   = 32;

  localparam int LUMA_R     = 13933;
  localparam int LUMA_G     = 46871;
  localparam int LUMA_B     = 4732;
  localparam int LUMA_SHIFT = 16;
  localparam int PROD_BITS  = 24;

  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [2:0] CH_GREY  = 3'd1;
  localparam logic [2:0] CH_RGB   = 3'd3;
  localparam logic [2:0] CH_RESET = CH_GREY;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_BUMP,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [BIN_BITS-1:0]   addr;
  } cmd_t;

endpackage

@@ hdl/lhe_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module lhe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/lhe_front.sv @@
// Front end: accepts items, holds the channel count, computes the target bin.
module lhe_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [1:0]                    s_tuser,
  input  logic [31:0]                   s_tdata,
  output logic                          push,
  output lhe_pkg::cmd_t                 push_cmd,
  input  logic                          q_full
);
  import lhe_pkg::*;

  logic [2:0]              channel_count;
  logic                    s1_valid;
  cmd_kind_t               s1_kind;
  logic                    s1_rgb;
  logic [BIN_BITS-1:0]     s1_addr;
  logic [PROD_BITS-1:0]    s1_pr;
  logic [PROD_BITS-1:0]    s1_pg;
  logic [PROD_BITS-1:0]    s1_pb;

  logic [PIX_BITS-1:0]     in_r;
  logic [PIX_BITS-1:0]     in_g;
  logic [PIX_BITS-1:0]     in_b;
  logic [BIN_BITS-1:0]     in_sel;
  logic                    keep;
  cmd_kind_t               in_kind;
  logic [PROD_BITS-1:0]    luma_sum;

  assign in_r   = s_tdata[7:0];
  assign in_g   = s_tdata[15:8];
  assign in_b   = s_tdata[23:16];
  assign in_sel = s_tdata[31:24];

  assign s_tready = !s1_valid || !q_full;

  always_comb begin
    keep    = 1'b0;
    in_kind = CMD_CLEAR;
    unique case (s_tuser)
      OP_CLEAR: begin
        keep    = 1'b1;
        in_kind = CMD_CLEAR;
      end
      OP_PIXEL: begin
        keep    = (channel_count == CH_GREY) || (channel_count == CH_RGB);
        in_kind = CMD_BUMP;
      end
      OP_READ: begin
        keep    = 1'b1;
        in_kind = CMD_READ;
      end
      default: begin
        keep    = 1'b0;
        in_kind = CMD_CLEAR;
      end
    endcase
  end

  assign luma_sum = s1_pr + s1_pg + s1_pb;

  always_comb begin
    push_cmd.kind = s1_kind;
    push_cmd.addr = s1_rgb ? luma_sum[LUMA_SHIFT +: BIN_BITS] : s1_addr;
  end

  assign push = s1_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CH_RESET;
      s1_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        channel_count <= cfg_data;
      end
      if (s_tready) begin
        s1_valid <= s_tvalid && keep;
      end
    end
    if (s_tready) begin
      s1_kind <= in_kind;
      s1_rgb  <= (in_kind == CMD_BUMP) && (channel_count == CH_RGB);
      s1_addr <= (in_kind == CMD_READ) ? in_sel : in_r;
      s1_pr   <= PROD_BITS'(in_r * PROD_BITS'(LUMA_R));
      s1_pg   <= PROD_BITS'(in_g * PROD_BITS'(LUMA_G));
      s1_pb   <= PROD_BITS'(in_b * PROD_BITS'(LUMA_B));
    end
  end

endmodule

@@ hdl/lhe_queue.sv @@
// Short command queue between the front end and the bin update engine.
module lhe_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lhe_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output lhe_pkg::cmd_t  pop_cmd,
  output logic           not_empty
);
  import lhe_pkg::*;

  cmd_t                  slots [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr;
  logic [Q_PTR_BITS-1:0] rd_ptr;
  logic [Q_CNT_BITS-1:0] count;

  assign full      = (count == Q_CNT_BITS'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign pop_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ hdl/lhe_back.sv @@
// Back end: bin memory read-modify-write, bulk clear and read-out register.
module lhe_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  lhe_pkg::cmd_t  q_cmd,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [39:0]    m_tdata
);
  import lhe_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t                  state;
  cmd_t                    cur;
  logic [NUM_BINS-1:0]     bin_valid;
  logic                    hit;
  logic [BIN_BITS-1:0]     out_index;
  logic [OUT_BITS-1:0]     out_count;

  logic                    ram_re;
  logic                    ram_we;
  logic [COUNT_BITS-1:0]   ram_rdata;
  logic [COUNT_BITS-1:0]   cnt;
  logic [COUNT_BITS-1:0]   cnt_next;
  logic                    load_out;

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign ram_re   = q_pop && (q_cmd.kind != CMD_CLEAR);
  assign cnt      = hit ? ram_rdata : '0;
  assign cnt_next = (&cnt) ? cnt : cnt + 1'b1;
  assign ram_we   = (state == ST_EXEC) && (cur.kind == CMD_BUMP);
  assign load_out = (state == ST_EXEC) && (cur.kind == CMD_READ) &&
                    (!m_tvalid || m_tready);
  assign m_tdata  = {out_count, out_index};

  lhe_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(NUM_BINS)
  ) u_bins (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cur.addr),
    .wdata(cnt_next),
    .re   (ram_re),
    .raddr(q_cmd.addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bin_valid <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_cmd.kind == CMD_CLEAR) begin
              bin_valid <= '0;
            end else begin
              state <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          if (ram_we) begin
            bin_valid[cur.addr] <= 1'b1;
            state               <= ST_IDLE;
          end else if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
    if (ram_re) begin
      cur <= q_cmd;
      hit <= bin_valid[q_cmd.addr];
    end
    if (load_out) begin
      out_index <= cur.addr;
      out_count <= OUT_BITS'(cnt);
    end
  end

endmodule

@@ hdl/luma_histogram_engine_unit.sv @@
// Top level of the luma histogram engine: front end, command queue, bin engine.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: op; tdata: grey_or_red, green, blue, bin_select
// m_*       out  m_tvalid/m_tready  tdata: bin_index, bin_count
// cfg_*     in   cfg_we             cfg_data: channel_count
//
// The front end takes one item per cycle while the queue is not full, into
// registered luma products, a combinational sum and a four-entry queue. The
// bin engine runs a clear in its idle state, and a pixel or a read as a memory
// read followed by an update or output load, before it pops the next command.
// Reset clears all bins at once through per-bin valid flags; no sweep is run.
// A full queue stalls the input; a held result stalls the bin engine once the
// next read reaches it.
module luma_histogram_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_data,   // channel_count
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,    // [1:0] op
  input  logic [31:0] s_tdata,    // [7:0] grey_or_red, [15:8] green, [23:16] blue,
                                  // [31:24] bin_select
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata     // [7:0] bin_index, [39:8] bin_count
);
  import lhe_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_pop;
  cmd_t q_cmd;
  logic q_valid;

  lhe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .s_tdata (s_tdata),
    .push    (push),
    .push_cmd(push_cmd),
    .q_full  (q_full)
  );

  lhe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_cmd),
    .not_empty(q_valid)
  );

  lhe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule
